### rtl/mtq_pkg.sv
`default_nettype none

package mtq_pkg;

   // request actions
   localparam logic [1:0] ACT_ENQ = 2'd0;
   localparam logic [1:0] ACT_DEQ = 2'd1;
   localparam logic [1:0] ACT_QRY = 2'd2;

   // response status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_DEQ_EMPTY = 2'd1;
   localparam logic [1:0] ST_QRY_EMPTY = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   localparam int unsigned DATA_W = 32;

   // result of the shared comparator
   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_res_type;

endpackage

`default_nettype wire

### rtl/max_tracking_queue_core.sv
// max_tracking_queue_core: a FIFO of signed 32-bit values that also reports
// its largest held value, tracked with a monotonic deque of candidate maxima.
// req channel (req_valid/req_stall): req_action 0 enqueue req_value,
// 1 dequeue the oldest value, 2 or 3 query the maximum.
// rsp channel (rsp_valid/rsp_stall): one beat per request with rsp_status
// (0 ok, 1 dequeue on empty, 2 query on empty, 3 enqueue on full, dropped)
// and rsp_max_value, the maximum after the request, 0 when empty.
// One request is worked at a time; req_stall is high while it is in flight.
// Steps per request: query and rejected requests go straight to the done
// state; dequeue reads the leaving value back and, when the deque front
// leaves and the queue still holds items, reads the new front; enqueue pops
// smaller trailing maxima one at a time, each pop being one read of the
// maxima memory and one pass through the shared comparator, then appends
// behind the remaining tail or into the emptied deque. Pops are amortized
// over the enqueues.
// The finished beat sits in an output register; a new request is accepted
// while it waits, and the next result waits in its final state until the
// receiver drops rsp_stall. Reset empties both queues at once (counters
// only, no memory clearing pass) and holds req_stall high.
`default_nettype none

module max_tracking_queue_core #(
   parameter int DEPTH = 1024
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_action,
   input  wire logic signed [mtq_pkg::DATA_W-1:0]   req_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_status,
   output logic signed [mtq_pkg::DATA_W-1:0]        rsp_max_value
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = AW + 1;
   localparam int DW = mtq_pkg::DATA_W;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_POP   = 6'b000010,
      S_CMP   = 6'b000100,
      S_DEQ   = 6'b001000,
      S_FRONT = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

   // circular index add
   function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   state_type state_ff, state_in;
   logic [AW-1:0] item_head_ff, item_head_in;
   logic [CW-1:0] item_count_ff, item_count_in;
   logic [AW-1:0] max_head_ff, max_head_in;
   logic [CW-1:0] max_count_ff, max_count_in;
   logic signed [DW-1:0] value_ff, value_in;
   logic signed [DW-1:0] front_ff, front_in;
   logic [1:0] status_ff, status_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_status_ff, rsp_status_in;
   logic signed [DW-1:0] rsp_max_ff, rsp_max_in;

   logic          item_we;
   logic [AW-1:0] item_waddr;
   logic [DW-1:0] item_rdata;
   logic          max_we;
   logic [AW-1:0] max_waddr;
   logic [AW-1:0] max_raddr;
   logic [DW-1:0] max_rdata;

   logic signed [DW-1:0] cmp_a;
   logic signed [DW-1:0] cmp_b;
   mtq_pkg::cmp_res_type cmp_res;

   logic item_full;
   logic item_empty;

   // value store and maxima deque store
   mtq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_item_ram (
      .clock   (clock),
      .wr_en   (item_we),
      .wr_addr (item_waddr),
      .wr_data (value_in),
      .rd_addr (item_head_ff),
      .rd_data (item_rdata)
   );

   mtq_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_max_ram (
      .clock   (clock),
      .wr_en   (max_we),
      .wr_addr (max_waddr),
      .wr_data (value_ff),
      .rd_addr (max_raddr),
      .rd_data (max_rdata)
   );

   // tail candidate against new value, or leaving value against front
   assign cmp_a = (state_ff == S_CMP) ? $signed(max_rdata) : $signed(item_rdata);
   assign cmp_b = (state_ff == S_CMP) ? value_ff : front_ff;

   mtq_cmp u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .res  (cmp_res)
   );

   assign item_full  = (item_count_ff == CW'(DEPTH));
   assign item_empty = (item_count_ff == '0);

   assign item_waddr = wrap_add(item_head_ff, item_count_ff);
   assign max_waddr  = wrap_add(max_head_ff, max_count_ff);
   assign max_raddr  = (state_ff == S_DEQ) ? wrap_add(max_head_ff, CW'(1))
                                           : wrap_add(max_head_ff, max_count_ff - CW'(1));

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_head_in  = item_head_ff;
      item_count_in = item_count_ff;
      max_head_in   = max_head_ff;
      max_count_in  = max_count_ff;
      value_in      = value_ff;
      front_in      = front_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_max_in    = rsp_max_ff;
      item_we       = 1'b0;
      max_we        = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in = req_value;
               case (req_action)
                  mtq_pkg::ACT_ENQ: begin
                     if (item_full) begin
                        status_in = mtq_pkg::ST_FULL;
                        state_in  = S_DONE;
                     end else begin
                        item_we       = 1'b1;
                        item_count_in = item_count_ff + CW'(1);
                        status_in     = mtq_pkg::ST_OK;
                        state_in      = S_POP;
                     end
                  end
                  mtq_pkg::ACT_DEQ: begin
                     if (item_empty) begin
                        status_in = mtq_pkg::ST_DEQ_EMPTY;
                        state_in  = S_DONE;
                     end else begin
                        item_head_in  = wrap_add(item_head_ff, CW'(1));
                        item_count_in = item_count_ff - CW'(1);
                        status_in     = mtq_pkg::ST_OK;
                        state_in      = S_DEQ;
                     end
                  end
                  default: begin
                     status_in = item_empty ? mtq_pkg::ST_QRY_EMPTY : mtq_pkg::ST_OK;
                     state_in  = S_DONE;
                  end
               endcase
            end
         end
         // either append to an empty deque or read the tail
         S_POP: begin
            if (max_count_ff == '0) begin
               max_we       = 1'b1;
               front_in     = value_ff;
               max_count_in = CW'(1);
               state_in     = S_DONE;
            end else begin
               state_in = S_CMP;
            end
         end
         // drop a smaller tail, else append behind it
         S_CMP: begin
            if (cmp_res.lt) begin
               max_count_in = max_count_ff - CW'(1);
               state_in     = S_POP;
            end else begin
               max_we       = 1'b1;
               max_count_in = max_count_ff + CW'(1);
               state_in     = S_DONE;
            end
         end
         // leaving value read back; retire the front if it matches
         S_DEQ: begin
            state_in = S_DONE;
            if (max_count_ff != '0 && cmp_res.eq) begin
               max_head_in  = wrap_add(max_head_ff, CW'(1));
               max_count_in = max_count_ff - CW'(1);
               if (!item_empty && max_count_ff != CW'(1)) begin
                  state_in = S_FRONT;
               end
            end
            if (item_empty) begin
               max_count_in = '0;
            end
         end
         S_FRONT: begin
            front_in = $signed(max_rdata);
            state_in = S_DONE;
         end
         // hand the beat to the output register once it is free
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_max_in    = item_empty ? '0 : front_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         item_head_ff  <= '0;
         item_count_ff <= '0;
         max_head_ff   <= '0;
         max_count_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         item_head_ff  <= item_head_in;
         item_count_ff <= item_count_in;
         max_head_ff   <= max_head_in;
         max_count_ff  <= max_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      value_ff      <= value_in;
      front_ff      <= front_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_max_ff    <= rsp_max_in;
   end

   assign req_stall     = reset || (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_max_value = rsp_max_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      item_count_ff <= CW'(DEPTH))
      else $error("item count above depth");

   a_deque_not_longer: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (max_count_ff <= item_count_ff))
      else $error("maxima deque longer than queue");

   a_deque_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && item_count_ff != '0) |-> (max_count_ff != '0))
      else $error("queue holds items but deque is empty");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted request left no work");

   a_cmp_has_tail: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (max_count_ff != '0))
      else $error("tail compare on empty deque");

endmodule

`default_nettype wire

### rtl/mtq_ram.sv
`default_nettype none

module mtq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/mtq_cmp.sv
`default_nettype none

module mtq_cmp (
   input  wire logic signed [mtq_pkg::DATA_W-1:0] op_a,
   input  wire logic signed [mtq_pkg::DATA_W-1:0] op_b,
   output mtq_pkg::cmp_res_type                   res
);

   // signed two's complement compare shared by the tail pop and the front check
   always_comb begin
      res.lt = (op_a < op_b);
      res.eq = (op_a == op_b);
   end

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = 1024;
   localparam int FILL_LEVEL = 120;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 16;
   // action code 3 behaves as a query
   localparam logic [1:0] ACT_QRY_ALT = 2'd3;
   localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
   localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] max_value;
   } max_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_action = mtq_pkg::ACT_QRY;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [31:0] rsp_max_value;

   // predicted contents of the block
   logic signed [31:0] held_items[$];
   logic signed [31:0] max_candidates[$];
   max_report_type max_reports_q[$];
   max_report_type seen_report;

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   max_tracking_queue_core #(
      .DEPTH(QUEUE_DEPTH)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_max_value(rsp_max_value)
   );

   always #10 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL max_tracking_queue_core");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // fifo plus monotonic deque of candidate maxima, one report per request
   function automatic max_report_type track_queue_max(input logic [1:0] act,
                                                      input logic signed [31:0] val);
      max_report_type rep;
      logic signed [31:0] leaving;
      rep.status = mtq_pkg::ST_OK;
      if (act == mtq_pkg::ACT_ENQ) begin
         if (held_items.size() >= QUEUE_DEPTH) begin
            rep.status = mtq_pkg::ST_FULL;
         end else begin
            held_items.push_back(val);
            // drop trailing candidates strictly below the new value
            while (max_candidates.size() > 0 && max_candidates[$] < val)
               void'(max_candidates.pop_back());
            max_candidates.push_back(val);
         end
      end else if (act == mtq_pkg::ACT_DEQ) begin
         if (held_items.size() == 0) begin
            rep.status = mtq_pkg::ST_DEQ_EMPTY;
         end else begin
            leaving = held_items.pop_front();
            if (max_candidates.size() > 0 && max_candidates[0] == leaving)
               void'(max_candidates.pop_front());
            if (held_items.size() == 0)
               max_candidates.delete();
         end
      end else begin
         if (held_items.size() == 0)
            rep.status = mtq_pkg::ST_QRY_EMPTY;
      end
      rep.max_value = (held_items.size() == 0) ? '0 : max_candidates[0];
      return rep;
   endfunction

   // one request beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [1:0] act, input logic signed [31:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      max_reports_q.push_back(track_queue_max(act, val));
   endtask

   // compare each response beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (max_reports_q.size() == 0) begin
            report_mismatch("unexpected response status", 32'(rsp_status), '0);
         end else begin
            seen_report = max_reports_q.pop_front();
            if (rsp_status !== seen_report.status)
               report_mismatch("status", 32'(rsp_status), 32'(seen_report.status));
            if (rsp_max_value !== seen_report.max_value)
               report_mismatch("max_value", rsp_max_value, seen_report.max_value);
         end
      end
   end

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return MOST_NEGATIVE;
         1: return MOST_POSITIVE;
         2, 3, 4, 5: return $signed($urandom_range(16)) - 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [1:0] pick_action(input int enq_pct);
      int r;
      r = $urandom_range(19);
      if ($urandom_range(99) < enq_pct) return mtq_pkg::ACT_ENQ;
      if (r < 16) return mtq_pkg::ACT_DEQ;
      if (r < 19) return mtq_pkg::ACT_QRY;
      return ACT_QRY_ALT;
   endfunction

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      stall_pct = recv_pct;
   endtask

   // dequeue and query on an empty queue, both query codes
   task automatic test_empty_requests();
      send_beat(mtq_pkg::ACT_DEQ, MOST_POSITIVE);
      send_beat(mtq_pkg::ACT_QRY, MOST_NEGATIVE);
      send_beat(ACT_QRY_ALT, '1);
   endtask

   // extreme values, smaller values pushed behind the front
   task automatic test_extreme_values();
      send_beat(mtq_pkg::ACT_ENQ, MOST_NEGATIVE);
      send_beat(mtq_pkg::ACT_QRY, '0);
      send_beat(mtq_pkg::ACT_ENQ, MOST_POSITIVE);
      send_beat(mtq_pkg::ACT_ENQ, -32'sd1);
      send_beat(mtq_pkg::ACT_ENQ, 32'sd0);
      send_beat(mtq_pkg::ACT_ENQ, MOST_POSITIVE);
      send_beat(ACT_QRY_ALT, '0);
      repeat (5) send_beat(mtq_pkg::ACT_DEQ, '1);
      send_beat(mtq_pkg::ACT_DEQ, '0);
      send_beat(mtq_pkg::ACT_QRY, '0);
   endtask

   // duplicate maxima leave one at a time
   task automatic test_equal_values();
      send_beat(mtq_pkg::ACT_ENQ, 32'sd5);
      send_beat(mtq_pkg::ACT_ENQ, 32'sd5);
      send_beat(mtq_pkg::ACT_ENQ, 32'sd3);
      send_beat(mtq_pkg::ACT_ENQ, 32'sd5);
      repeat (4) send_beat(mtq_pkg::ACT_DEQ, '0);
   endtask

   // non-increasing values grow a long deque, one large value pops all below it
   task automatic test_fill_and_drain();
      logic signed [31:0] fill_value;
      fill_value = MOST_POSITIVE;
      while (held_items.size() > 0) send_beat(mtq_pkg::ACT_DEQ, '0);
      while (held_items.size() < FILL_LEVEL) begin
         send_beat(mtq_pkg::ACT_ENQ, fill_value);
         fill_value = fill_value - $signed($urandom_range(2));
      end
      send_beat(mtq_pkg::ACT_ENQ, MOST_POSITIVE);
      send_beat(mtq_pkg::ACT_ENQ, MOST_NEGATIVE);
      send_beat(mtq_pkg::ACT_QRY, '0);
      while (held_items.size() > 0) send_beat(mtq_pkg::ACT_DEQ, $urandom);
      send_beat(mtq_pkg::ACT_DEQ, '0);
   endtask

   task automatic test_random_traffic(input int count, input int enq_pct);
      repeat (count) send_beat(pick_action(enq_pct), pick_value());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      set_idling(0, 0);
      test_empty_requests();
      test_extreme_values();
      test_equal_values();
      test_random_traffic(80, 50);
      test_fill_and_drain();

      set_idling(83, 0);
      test_random_traffic(65, 55);
      set_idling(0, 83);
      test_random_traffic(65, 45);
      set_idling(27, 27);
      test_random_traffic(65, 50);

      // let outstanding responses arrive
      req_valid <= 1'b0;
      while (max_reports_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("PASS max_tracking_queue_core");
      else
         $display("FAIL max_tracking_queue_core");
      $finish;
   end

endmodule

`default_nettype wire

### files.f
rtl/mtq_pkg.sv
rtl/mtq_ram.sv
rtl/mtq_cmp.sv
rtl/max_tracking_queue_core.sv
test/tb.sv
